// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the percent decoder output stage.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define UPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/upd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Percent decoder package
// Character codes, escape states and the result group passed between stages.
// ---------------------------------------------------------------------------
package upd_pkg;

  // Character codes.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Most output bytes that one input item can cause.
  localparam int unsigned MAX_RESULTS = 3;

  // Escape tracking state, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  // Output bytes caused by one item.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  cnt;
    logic                        last;
  } group_t;

endpackage

// ===== design/upd_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Percent decoder escape logic
// Turns one input byte and the escape state into up to three output bytes.
// ---------------------------------------------------------------------------
module upd_decode
  import upd_pkg::*;
(
  input  phase_t     phase,
  input  logic [7:0] held,
  input  logic       plus_as_space,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output group_t     grp,
  output phase_t     phase_next,
  output logic [7:0] held_next
);

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
    hex_value = v[3:0];
  endfunction

  logic       b_hex;
  logic       p_emit;
  logic [7:0] p_byte;
  logic       p_start;
  phase_t     p_phase;

  assign b_hex   = is_hex(in_byte);
  assign p_phase = p_start ? PH_PCT : PH_IDLE;

  // Handling of a byte with no escape pending.
  always_comb begin
    p_emit  = 1'b1;
    p_byte  = in_byte;
    p_start = 1'b0;
    if (in_byte == CH_PERCENT) begin
      if (!in_last) begin
        p_emit  = 1'b0;
        p_start = 1'b1;
      end
    end else if (in_byte == CH_PLUS && plus_as_space) begin
      p_byte = CH_SPACE;
    end
  end

  // Escape state handling and result assembly.
  always_comb begin
    grp.bytes  = '0;
    grp.cnt    = 2'd0;
    grp.last   = in_last;
    phase_next = PH_IDLE;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (b_hex) begin
          if (in_last) begin
            grp.bytes[0] = CH_PERCENT;
            grp.bytes[1] = in_byte;
            grp.cnt      = 2'd2;
          end else begin
            held_next  = in_byte;
            phase_next = PH_DIGIT;
          end
        end else begin
          grp.bytes[0] = CH_PERCENT;
          grp.bytes[1] = p_byte;
          grp.cnt      = p_emit ? 2'd2 : 2'd1;
          phase_next   = p_phase;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          grp.bytes[0] = {hex_value(held), hex_value(in_byte)};
          grp.cnt      = 2'd1;
        end else begin
          grp.bytes[0] = CH_PERCENT;
          grp.bytes[1] = held;
          grp.bytes[2] = p_byte;
          grp.cnt      = p_emit ? 2'd3 : 2'd2;
          phase_next   = p_phase;
        end
      end
      default: begin
        grp.bytes[0] = p_byte;
        grp.cnt      = p_emit ? 2'd1 : 2'd0;
        phase_next   = p_phase;
      end
    endcase
    // The string end clears any pending escape.
    if (in_last) begin
      phase_next = PH_IDLE;
      held_next  = 8'h00;
    end
  end

endmodule

// ===== design/upd_emit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Percent decoder output stage
// Holds one result group and sends its bytes out one per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module upd_emit
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_en,
  input  group_t     grp,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  logic       busy;
  logic [1:0] pos;
  group_t     grp_q;
  logic       out_fire;
  logic       final_byte;

  assign out_fire   = busy && !out_stall;
  assign final_byte = (pos == grp_q.cnt - 2'd1);
  assign can_load   = !busy || (out_fire && final_byte);

  // Control: busy flag and byte position within the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (load_en) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (out_fire) begin
      if (final_byte) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  // Group payload register.
  always_ff @(posedge clk) begin
    if (load_en) begin
      grp_q <= grp;
    end
  end

  // Byte selection for the current position.
  always_comb begin
    case (pos)
      2'd0:    out_byte = grp_q.bytes[0];
      2'd1:    out_byte = grp_q.bytes[1];
      default: out_byte = grp_q.bytes[2];
    endcase
  end

  assign out_valid  = busy;
  assign run_last   = final_byte;
  assign string_end = final_byte && grp_q.last;

  `UPD_ASSERT(a_pos_in_group, busy |-> (pos < grp_q.cnt), "position beyond group")
  `UPD_ASSERT(a_load_starts, load_en |=> (busy && pos == 2'd0), "group load lost")
  `UPD_ASSERT(a_drain_ends, (out_fire && final_byte && !load_en) |=> !busy,
              "group not released after final byte")
  `UPD_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy, "output busy after reset")

endmodule

// ===== design/url_percent_decoder_top.sv =====
`timescale 1ns / 1ps
// Latency: the first result of an item is presented the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one byte and the
// receiver does not stall; an item that yields two or three bytes holds the input
// until the single output register has sent its bytes, one per cycle when not stalled.
// Reset: synchronous, active high; clears escape state and sets plus_as_space.
// ---------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of percent escapes and plus signs, one byte per item.
// ---------------------------------------------------------------------------
module url_percent_decoder_top
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  logic       plus_as_space;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  group_t     grp;
  logic       can_load;
  logic       in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign in_fire   = in_valid && can_load;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      plus_as_space <= cfg_data;
    end
  end

  // Escape state, updated on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
    end else if (in_fire) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  upd_decode u_decode (
    .phase         (phase),
    .held          (held),
    .plus_as_space (plus_as_space),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .grp           (grp),
    .phase_next    (phase_next),
    .held_next     (held_next)
  );

  upd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_en    (in_fire && grp.cnt != 2'd0),
    .grp        (grp),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

// ===== bench/url_percent_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder testbench
// Drives encoded strings into the decoder and checks every decoded byte, its
// run marker and its string-end flag against the table's values or a cycle-free
// model of the escape logic. A short table of hand-picked strings comes first, then
// random strings under four traffic patterns, with the plus-as-space mode toggled.
// ---------------------------------------------------------------------------
module url_percent_decoder_top_tb
  import upd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_GAP       = 16;

  // One decoded byte as the receiver should see it.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } dec_byte_t;

  // One row of the hand-written strings; n_bytes below zero means the model decides.
  typedef struct {
    logic [7:0] b;
    logic       l;
    int         n_bytes;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  // Escape tracking of the model.
  phase_t     esc_phase = PH_IDLE;
  logic [7:0] held_char = 8'h00;
  logic       plus_mode = 1'b1;

  dec_byte_t  expected_bytes[$];
  int         error_count = 0;
  int         checked_bytes = 0;
  int         items_sent = 0;
  int         mode_writes = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         cycle_count = 0;
  logic       hold_req = 1'b0;
  logic       hold_off = 1'b0;

  // Hand-picked strings: plain bytes, escapes of both cases, broken escapes
  // and escapes cut short by the end of the string.
  dir_row_t dir_rows [0:26] = '{
    '{"A",        1'b0,  1, "A",        8'h00,      8'h00},
    '{8'h00,      1'b0,  1, 8'h00,      8'h00,      8'h00},
    '{8'hFF,      1'b0,  1, 8'hFF,      8'h00,      8'h00},
    '{CH_PLUS,    1'b0,  1, CH_SPACE,   8'h00,      8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"a",        1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"F",        1'b0,  1, 8'hAF,      8'h00,      8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"G",        1'b0,  2, CH_PERCENT, "G",        8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"3",        1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"z",        1'b0,  3, CH_PERCENT, "3",        "z"},
    '{CH_PERCENT, 1'b0, -1, 8'h00,      8'h00,      8'h00},
    '{CH_PERCENT, 1'b0, -1, 8'h00,      8'h00,      8'h00},
    '{"4",        1'b0, -1, 8'h00,      8'h00,      8'h00},
    '{"0",        1'b0, -1, 8'h00,      8'h00,      8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"9",        1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{CH_PLUS,    1'b0,  3, CH_PERCENT, "9",        CH_SPACE},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{8'h80,      1'b0,  2, CH_PERCENT, 8'h80,      8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"9",        1'b1,  2, CH_PERCENT, "9",        8'h00},
    '{CH_PERCENT, 1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{"B",        1'b0,  0, 8'h00,      8'h00,      8'h00},
    '{CH_PERCENT, 1'b1,  3, CH_PERCENT, "B",        CH_PERCENT},
    '{CH_PERCENT, 1'b1,  1, CH_PERCENT, 8'h00,      8'h00}
  };

  url_percent_decoder_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hex digits are 0-9, A-F and a-f; nothing at 128 or above qualifies.
  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Letters of either case sit one above a multiple of 16, so adding nine
  // to the low nibble gives their value.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] random_hex();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(21)];
  endfunction

  // Advances the escape state by one input byte and returns the bytes it releases.
  function automatic int decode_step(input logic [7:0] b, input logic l,
                                     output logic [7:0] o [3]);
    int   n;
    logic fresh;
    n = 0;
    fresh = 1'b1;
    o[0] = 8'h00;
    o[1] = 8'h00;
    o[2] = 8'h00;
    case (esc_phase)
      PH_PCT: begin
        if (is_hex_char(b)) begin
          fresh = 1'b0;
          if (l) begin
            o[0] = CH_PERCENT;
            o[1] = b;
            n = 2;
          end else begin
            held_char = b;
            esc_phase = PH_DIGIT;
          end
        end else begin
          o[0] = CH_PERCENT;
          n = 1;
        end
      end
      PH_DIGIT: begin
        if (is_hex_char(b)) begin
          fresh = 1'b0;
          o[0] = {nibble_of(held_char), nibble_of(b)};
          n = 1;
          esc_phase = PH_IDLE;
        end else begin
          o[0] = CH_PERCENT;
          o[1] = held_char;
          n = 2;
        end
      end
      default: ;
    endcase
    // A byte that breaks an escape is handled as if nothing were pending.
    if (fresh) begin
      esc_phase = PH_IDLE;
      if (b == CH_PERCENT && !l) begin
        esc_phase = PH_PCT;
      end else begin
        o[n] = (b == CH_PLUS && plus_mode) ? CH_SPACE : b;
        n = n + 1;
      end
    end
    if (l) begin
      esc_phase = PH_IDLE;
      held_char = 8'h00;
    end
    return n;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offers one item after a random gap and records what it should produce.
  task automatic send_item(input logic [7:0] b, input logic l, input int n_typed,
                           input logic [7:0] t0, input logic [7:0] t1,
                           input logic [7:0] t2);
    int         gap;
    int         n;
    logic [7:0] o [3];
    dec_byte_t  e;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    n = decode_step(b, l, o);
    if (n_typed >= 0) begin
      n = n_typed;
      o[0] = t0;
      o[1] = t1;
      o[2] = t2;
    end
    for (int k = 0; k < n; k++) begin
      e.data = o[k];
      e.run_end = (k == n - 1);
      e.str_end = (k == n - 1) && l;
      expected_bytes = {expected_bytes, e};
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode changes only happen with the decoder empty and between strings.
  task automatic set_plus_mode(input logic v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    plus_mode = v;
    mode_writes++;
  endtask

  // Mostly well-formed escapes with random digits, mixed with plus signs,
  // broken or dangling escapes and arbitrary bytes.
  task automatic send_random_string();
    logic [7:0] chars[$];
    int         len;
    int         r;
    len = $urandom_range(1, 10);
    while (chars.size() < len) begin
      r = $urandom_range(99);
      if (r < 35) begin
        chars = {chars, CH_PERCENT, random_hex(), random_hex()};
      end else if (r < 45) begin
        chars = {chars, CH_PLUS};
      end else if (r < 57) begin
        chars = {chars, CH_PERCENT, random_hex(), 8'($urandom_range(255))};
      end else if (r < 62) begin
        chars = {chars, CH_PERCENT};
      end else begin
        chars = {chars, 8'($urandom_range(255))};
      end
    end
    // Sometimes drop the last byte, which can cut the string inside an escape.
    if ($urandom_range(3) == 0 && chars.size() > 1) void'(chars.pop_back());
    foreach (chars[i]) send_item(chars[i], i == chars.size() - 1, -1, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < count) send_random_string();
    in_valid <= 1'b0;
  endtask

  // Receiver: check each accepted byte, then pick the next stall.
  always @(posedge clk) begin
    dec_byte_t e;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h run_last=%0b string_end=%0b",
                             out_byte, run_last, string_end));
      end else begin
        e = expected_bytes.pop_front();
        checked_bytes++;
        if (out_byte !== e.data || run_last !== e.run_end || string_end !== e.str_end) begin
          flag_error($sformatf("expected %02h/%0b/%0b, got %02h/%0b/%0b",
                               e.data, e.run_end, e.str_end, out_byte, run_last, string_end));
        end
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off so the decoder backs up into its input.
  initial begin
    wait (hold_req === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d bytes outstanding.",
             expected_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: directed strings, then four traffic phases.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].n_bytes,
                dir_rows[i].e0, dir_rows[i].e1, dir_rows[i].e2);
    end
    in_valid <= 1'b0;

    set_plus_mode(1'b0);
    send_item(CH_PLUS, 1'b1, 1, CH_PLUS, 8'h00, 8'h00);
    in_valid <= 1'b0;
    @(posedge clk);

    hold_req = 1'b1;
    run_phase(0, 0, PHASE_ITEMS);
    set_plus_mode(1'b1);
    run_phase(53, 0, PHASE_ITEMS);
    set_plus_mode(1'b0);
    run_phase(0, 53, PHASE_ITEMS);
    set_plus_mode(1'b1);
    run_phase(35, 35, PHASE_ITEMS);

    wait_drained();
    foreach (expected_bytes[i]) begin
      flag_error($sformatf("byte %02h never arrived", expected_bytes[i].data));
    end

    $display("Sent %0d input bytes and checked %0d decoded bytes across four traffic mixes,",
             items_sent, checked_bytes);
    $display("with %0d mode writes and %0d errors.", mode_writes, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/upd_pkg.sv
design/upd_decode.sv
design/upd_emit.sv
design/url_percent_decoder_top.sv
bench/url_percent_decoder_top_tb.sv
